@@ hw/rtl/wga_pkg.sv @@
// Shared types, constants and tables for the weighted group aggregator.
// Used by the controller, the datapath and the top level; depends on nothing.
package wga_pkg;

	localparam int DEF_MAX_SOURCES  = 255;
	localparam int DEF_TARGET_COUNT = 1048576;

	localparam int S_DATA_W = 176;
	localparam int M_DATA_W = 56;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W    = 8;
	localparam int IDX_W    = 20;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [4:0] CORDIC_LAST = 5'd29;

	typedef enum logic [1:0] {
		MET_SUM   = 2'd0,
		MET_MEAN  = 2'd1,
		MET_COUNT = 2'd2,
		MET_ANGLE = 2'd3
	} metric_sel_t;

	typedef enum logic [2:0] {
		CFG_METRIC    = 3'd0,
		CFG_FILL      = 3'd1,
		CFG_NAN_M2O   = 3'd2,
		CFG_NAN_O2M   = 3'd3,
		CFG_IGN_MAP   = 3'd4,
		CFG_USE_EXTRA = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		metric_sel_t        metric;
		logic signed [31:0] fill;
		logic               nan_m2o;
		logic               nan_o2m;
		logic               ign_map;
		logic               use_extra;
	} cfg_t;

	typedef enum logic [3:0] {
		S_IDLE, S_ENTRY1, S_ENTRY2, S_DECIDE, S_BIGCHK, S_NORM, S_SQRT1,
		S_DOT, S_COSDIV, S_SQRT2, S_CORDIC, S_ANGFIN, S_MEANDIV, S_OUT
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_LOAD, OP_FILL, OP_W, OP_ACC, OP_NAN, OP_SUM, OP_COUNT,
		OP_MEAN_START, OP_MEAN_FIN, OP_BIG, OP_NORM, OP_NSQ, OP_DOT, OP_CLAMP,
		OP_CORDIC_INIT, OP_CORDIC, OP_ANGLE_FIN, OP_PUSH
	} dp_op_t;

	typedef struct packed {
		logic        no_sources;
		logic        last;
		logic        nan_now;
		metric_sel_t metric;
		logic        weight_zero;
		logic        big_zero;
		logic        norm_ok;
		logic        norm_zero;
		logic        div_done;
		logic        sqrt_done;
		logic        cordic_last;
		logic        out_free;
	} dp_status_t;

	// arctangent of 2^-i in Q0.30
	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837830;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd10: v = 30'd1048576;
			5'd11: v = 30'd524288;
			5'd12: v = 30'd262144;
			5'd13: v = 30'd131072;
			5'd14: v = 30'd65536;
			5'd15: v = 30'd32768;
			5'd16: v = 30'd16384;
			5'd17: v = 30'd8192;
			5'd18: v = 30'd4096;
			5'd19: v = 30'd2048;
			5'd20: v = 30'd1024;
			5'd21: v = 30'd512;
			5'd22: v = 30'd256;
			5'd23: v = 30'd128;
			5'd24: v = 30'd64;
			5'd25: v = 30'd32;
			5'd26: v = 30'd16;
			5'd27: v = 30'd8;
			5'd28: v = 30'd4;
			5'd29: v = 30'd2;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

@@ hw/rtl/wga_div.sv @@
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Stand-alone; shared by the weighted mean and the cosine in the datapath.
module wga_div #(
	parameter int NW = 80,
	parameter int DW = 48
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] quo_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [DW:0]   partial;
	logic          take;

	assign partial = {rem_q, quo_q[NW-1]};
	assign take    = partial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(NW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[NW-2:0], take};
			rem_q <= take ? DW'(partial - {1'b0, den_q}) : partial[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule

@@ hw/rtl/wga_sqrt.sv @@
// Digit-by-digit integer square root, two radicand bits per cycle.
// Stand-alone; used for the direction norm and the sine in the datapath.
module wga_sqrt #(
	parameter int IW = 64
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [IW-1:0]   radicand,
	output logic            done,
	output logic [IW/2-1:0] root
);
	localparam int OW = IW / 2;
	localparam int CW = $clog2(OW + 1);

	logic [IW-1:0] n_q;
	logic [IW-1:0] r_q;
	logic [IW-1:0] bit_q;
	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [IW:0]   trial;
	logic          take;

	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign take  = {1'b0, n_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CW'(OW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= radicand;
			r_q   <= '0;
			bit_q <= {2'b01, {(IW-2){1'b0}}};
		end else if (cnt_q != '0) begin
			if (take) begin
				n_q <= IW'({1'b0, n_q} - trial);
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[OW-1:0];
endmodule

@@ hw/rtl/wga_ctrl.sv @@
// Sequencing state machine: accepts items and steps the datapath.
// Depends on wga_pkg for the state, command and status types.
module wga_ctrl import wga_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  dp_status_t stat,
	output dp_op_t     op
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (s_tvalid) state_d = S_ENTRY1;
			S_ENTRY1: state_d = stat.no_sources ? S_OUT : S_ENTRY2;
			S_ENTRY2: state_d = stat.last ? S_DECIDE : S_IDLE;
			S_DECIDE: begin
				if (stat.nan_now) begin
					state_d = S_OUT;
				end else begin
					unique case (stat.metric)
						MET_MEAN:  state_d = stat.weight_zero ? S_OUT : S_MEANDIV;
						MET_ANGLE: state_d = S_BIGCHK;
						default:   state_d = S_OUT;
					endcase
				end
			end
			S_BIGCHK:  state_d = stat.big_zero ? S_OUT : S_NORM;
			S_NORM:    if (stat.norm_ok) state_d = S_SQRT1;
			S_SQRT1:   if (stat.sqrt_done) state_d = S_DOT;
			S_DOT:     state_d = stat.norm_zero ? S_OUT : S_COSDIV;
			S_COSDIV:  if (stat.div_done) state_d = S_SQRT2;
			S_SQRT2:   if (stat.sqrt_done) state_d = S_CORDIC;
			S_CORDIC:  if (stat.cordic_last) state_d = S_ANGFIN;
			S_ANGFIN:  state_d = S_OUT;
			S_MEANDIV: if (stat.div_done) state_d = S_OUT;
			S_OUT:     if (stat.out_free) state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		unique case (state_q)
			S_IDLE:   if (s_tvalid) op = OP_LOAD;
			S_ENTRY1: op = stat.no_sources ? OP_FILL : OP_W;
			S_ENTRY2: op = OP_ACC;
			S_DECIDE: begin
				if (stat.nan_now) begin
					op = OP_NAN;
				end else begin
					unique case (stat.metric)
						MET_SUM:   op = OP_SUM;
						MET_COUNT: op = OP_COUNT;
						MET_MEAN:  op = stat.weight_zero ? OP_NAN : OP_MEAN_START;
						MET_ANGLE: op = OP_BIG;
						default:   op = OP_NONE;
					endcase
				end
			end
			S_BIGCHK:  op = stat.big_zero ? OP_NAN : OP_NORM;
			S_NORM:    op = stat.norm_ok ? OP_NSQ : OP_NORM;
			S_SQRT1:   op = OP_NONE;
			S_DOT:     op = stat.norm_zero ? OP_NAN : OP_DOT;
			S_COSDIV:  if (stat.div_done) op = OP_CLAMP;
			S_SQRT2:   if (stat.sqrt_done) op = OP_CORDIC_INIT;
			S_CORDIC:  op = OP_CORDIC;
			S_ANGFIN:  op = OP_ANGLE_FIN;
			S_MEANDIV: if (stat.div_done) op = OP_MEAN_FIN;
			S_OUT:     if (stat.out_free) op = OP_PUSH;
			default:   op = OP_NONE;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
endmodule

@@ hw/rtl/wga_dp.sv @@
// Datapath: item registers, run accumulators, metric arithmetic, result register.
// Depends on wga_pkg, wga_div and wga_sqrt.
module wga_dp import wga_pkg::*; #(
	parameter int MAX_SOURCES  = DEF_MAX_SOURCES,
	parameter int TARGET_COUNT = DEF_TARGET_COUNT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dp_op_t              op,
	input  cfg_t                cfg,
	input  logic [S_DATA_W-1:0] in_data,
	input  logic                in_last,
	input  logic                in_nosrc,
	output dp_status_t          stat,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,
	output logic                m_tuser
);
	localparam logic [CNT_W-1:0] MaxCnt  = CNT_W'(MAX_SOURCES);
	localparam logic [IDX_W-1:0] LastIdx = IDX_W'(TARGET_COUNT - 1);

	// item
	logic signed [31:0] val_q;
	logic [16:0]        mw_q;
	logic [23:0]        ext_q;
	logic signed [15:0] sd_q [3];
	logic signed [15:0] td_q [3];
	logic               last_q, nosrc_q;

	// entry stage
	logic [24:0] w_q;
	logic        neg_q, full_q;

	// run accumulators
	logic signed [63:0] vacc_q;
	logic [47:0]        wacc_q;
	logic signed [55:0] dacc_q [3];
	logic [CNT_W-1:0]   cnt_q;
	logic               nanp_q;

	// angle
	logic signed [55:0] m_q [3];
	logic [55:0]        big_q;
	logic               dneg_q;
	logic signed [31:0] c_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic [4:0]         ci_q;

	logic signed [31:0] res_q;
	logic               rnan_q;

	logic               ov_q;
	logic [31:0]        ov_val_q;
	logic               ov_nan_q;
	logic [IDX_W-1:0]   ov_idx_q, tgt_q;

	// entry arithmetic
	logic [16:0]        agg;
	logic [40:0]        wprod;
	logic [24:0]        w_new;
	logic signed [33:0] sdot;
	logic signed [25:0] wz, sw;
	logic signed [57:0] vw;
	logic signed [41:0] dprod [3];

	// angle arithmetic
	logic [55:0]        mag [3];
	logic [55:0]        big_new;
	logic signed [25:0] mm [3];
	logic signed [51:0] sq [3];
	logic [63:0]        nsq;
	logic signed [41:0] tprod [3];
	logic signed [43:0] dot;
	logic [43:0]        dot_mag;
	logic [63:0]        vmag;
	logic [30:0]        qc;
	logic [61:0]        qc_sq;
	logic signed [33:0] dx, dy, at, zr;

	// shared units
	logic        div_start, sq_start, div_done, sq_done;
	logic [79:0] div_num, div_quo;
	logic [47:0] div_den;
	logic [63:0] sq_in;
	logic [31:0] sq_root;
	logic        qbig;

	wga_div #(.NW(80), .DW(48)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	wga_sqrt #(.IW(64)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_in),
		.done(sq_done), .root(sq_root)
	);

	always_comb begin
		agg   = cfg.ign_map ? ONE_Q16 : mw_q;
		wprod = agg * ext_q;
		w_new = cfg.use_extra ? wprod[40:16] : {8'd0, agg};
		sdot  = 34'(td_q[0] * sd_q[0]) + 34'(td_q[1] * sd_q[1]) + 34'(td_q[2] * sd_q[2]);
		wz    = $signed({1'b0, w_q});
		sw    = neg_q ? -wz : wz;
		vw    = val_q * wz;
		for (int i = 0; i < 3; i++) begin
			dprod[i] = sd_q[i] * sw;
			mag[i]   = dacc_q[i][55] ? 56'(-dacc_q[i]) : 56'(dacc_q[i]);
			mm[i]    = m_q[i][25:0];
			sq[i]    = mm[i] * mm[i];
			tprod[i] = td_q[i] * mm[i];
		end
		big_new = mag[0];
		if (mag[1] > big_new) big_new = mag[1];
		if (mag[2] > big_new) big_new = mag[2];
		nsq     = {12'd0, sq[0]} + {12'd0, sq[1]} + {12'd0, sq[2]};
		dot     = 44'(tprod[0]) + 44'(tprod[1]) + 44'(tprod[2]);
		dot_mag = dot[43] ? 44'(-dot) : 44'(dot);
		vmag    = vacc_q[63] ? 64'(-vacc_q) : 64'(vacc_q);
		qc      = (div_quo > 80'd1073741824) ? 31'd1073741824 : div_quo[30:0];
		qc_sq   = qc * qc;
		qbig    = |div_quo[79:31];
		dx      = cy_q >>> ci_q;
		dy      = cx_q >>> ci_q;
		at      = $signed({4'd0, atan_q30(ci_q)});
		zr      = (cz_q + 34'sd8192) >>> 14;
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = {vmag, 16'd0};
		div_den   = wacc_q;
		sq_start  = 1'b0;
		sq_in     = nsq;
		case (op)
			OP_MEAN_START: div_start = 1'b1;
			OP_DOT: begin
				div_start = 1'b1;
				div_num   = {20'd0, dot_mag, 16'd0};
				div_den   = {16'd0, sq_root};
			end
			OP_NSQ: sq_start = 1'b1;
			OP_CLAMP: begin
				sq_start = 1'b1;
				sq_in    = 64'h1000_0000_0000_0000 - {2'd0, qc_sq};
			end
			default: ;
		endcase
	end

	// run and output control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vacc_q  <= '0;
			wacc_q  <= '0;
			for (int i = 0; i < 3; i++) dacc_q[i] <= '0;
			cnt_q   <= '0;
			nanp_q  <= 1'b0;
			tgt_q   <= '0;
			ov_q    <= 1'b0;
			last_q  <= 1'b0;
			nosrc_q <= 1'b0;
			full_q  <= 1'b0;
			ci_q    <= '0;
		end else begin
			if (ov_q && m_tready) ov_q <= 1'b0;
			case (op)
				OP_LOAD: begin
					last_q  <= in_last;
					nosrc_q <= in_nosrc;
				end
				OP_W: begin
					full_q <= cnt_q >= MaxCnt;
					if ((cfg.nan_o2m && mw_q < ONE_Q16) || (cfg.nan_m2o && cnt_q >= MaxCnt))
						nanp_q <= 1'b1;
				end
				OP_ACC: begin
					if (!full_q) begin
						cnt_q  <= cnt_q + 1'b1;
						vacc_q <= vacc_q + {{22{vw[57]}}, vw[57:16]};
						wacc_q <= wacc_q + {23'd0, w_q};
						for (int i = 0; i < 3; i++)
							dacc_q[i] <= dacc_q[i] + {{14{dprod[i][41]}}, dprod[i]};
					end
				end
				OP_CORDIC_INIT: ci_q <= '0;
				OP_CORDIC:      ci_q <= ci_q + 1'b1;
				OP_PUSH: begin
					ov_q   <= 1'b1;
					vacc_q <= '0;
					wacc_q <= '0;
					for (int i = 0; i < 3; i++) dacc_q[i] <= '0;
					cnt_q  <= '0;
					nanp_q <= 1'b0;
					tgt_q  <= (tgt_q == LastIdx) ? '0 : tgt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				val_q    <= in_data[31:0];
				mw_q     <= in_data[48:32];
				ext_q    <= in_data[72:49];
				sd_q[0]  <= in_data[88:73];
				sd_q[1]  <= in_data[104:89];
				sd_q[2]  <= in_data[120:105];
				td_q[0]  <= in_data[136:121];
				td_q[1]  <= in_data[152:137];
				td_q[2]  <= in_data[168:153];
			end
			OP_W: begin
				w_q   <= w_new;
				neg_q <= sdot < 0;
			end
			OP_FILL: begin
				res_q  <= cfg.fill;
				rnan_q <= 1'b0;
			end
			OP_NAN: begin
				res_q  <= '0;
				rnan_q <= 1'b1;
			end
			OP_SUM: begin
				rnan_q <= 1'b0;
				if (vacc_q[63:31] == '0 || vacc_q[63:31] == '1) res_q <= vacc_q[31:0];
				else res_q <= vacc_q[63] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end
			OP_COUNT: begin
				res_q  <= {8'd0, cnt_q, 16'd0};
				rnan_q <= 1'b0;
			end
			OP_MEAN_FIN: begin
				rnan_q <= 1'b0;
				if (vacc_q[63]) res_q <= qbig ? 32'sh8000_0000 : -$signed(div_quo[31:0]);
				else            res_q <= qbig ? 32'sh7FFF_FFFF : $signed(div_quo[31:0]);
			end
			OP_BIG: begin
				big_q <= big_new;
				for (int i = 0; i < 3; i++) m_q[i] <= dacc_q[i];
			end
			OP_NORM: begin
				// bring the largest magnitude into [2^23, 2^24)
				if (|big_q[55:24]) begin
					big_q <= big_q >> 1;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >>> 1;
				end else if (!big_q[23]) begin
					big_q <= big_q << 1;
					for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] <<< 1;
				end
			end
			OP_DOT:   dneg_q <= dot < 0;
			OP_CLAMP: c_q <= dneg_q ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
			OP_CORDIC_INIT: begin
				if (c_q < 0) begin
					cx_q <= $signed({2'd0, sq_root});
					cy_q <= -34'(c_q);
					cz_q <= HALF_PI_Q30;
				end else begin
					cx_q <= 34'(c_q);
					cy_q <= $signed({2'd0, sq_root});
					cz_q <= '0;
				end
			end
			OP_CORDIC: begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + at;
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - at;
				end
			end
			OP_ANGLE_FIN: begin
				res_q  <= {{12{zr[33]}}, zr[19:0]};
				rnan_q <= 1'b0;
			end
			OP_PUSH: begin
				ov_val_q <= res_q;
				ov_nan_q <= rnan_q;
				ov_idx_q <= tgt_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		stat.no_sources  = nosrc_q;
		stat.last        = last_q;
		stat.nan_now     = nanp_q || (cfg.nan_m2o && cnt_q > CNT_W'(1));
		stat.metric      = cfg.metric;
		stat.weight_zero = (wacc_q == '0);
		stat.big_zero    = (big_q == '0);
		stat.norm_ok     = (big_q[55:24] == '0) && big_q[23];
		stat.norm_zero   = (sq_root == '0);
		stat.div_done    = div_done;
		stat.sqrt_done   = sq_done;
		stat.cordic_last = (ci_q == CORDIC_LAST);
		stat.out_free    = !ov_q || m_tready;
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {4'd0, ov_idx_q, ov_val_q};
	assign m_tuser  = ov_nan_q;
endmodule

@@ hw/rtl/weighted_group_aggregator.sv @@
// Top level of the weighted group aggregator: configuration registers and wiring.
// Depends on wga_pkg, wga_ctrl and wga_dp.
//
// Each target arrives as a run of source entries, one beat per entry, closed by
// tlast; a target with no sources is a single beat with tuser set. An entry passes
// through accept, weight and accumulate, and the block takes one entry at a
// time. The closing beat adds the result work: a decision and the output step
// for sum, count or NaN; the 80-step shared divider for the weighted mean; and
// for the angle, the normalising shift loop (one bit per cycle), two 32-step
// square roots, the divider and the 30-step CORDIC. A fill beat goes from accept
// to fill and output. One result is held in the output register, so the next run
// is taken while it waits.
module weighted_group_aggregator import wga_pkg::*; #(
	parameter int MAX_SOURCES  = DEF_MAX_SOURCES,
	parameter int TARGET_COUNT = DEF_TARGET_COUNT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// src_value[31:0] map_weight[48:32] extra_weight[72:49] src_dir_x[88:73]
	// src_dir_y[104:89] src_dir_z[120:105] tgt_dir_x[136:121] tgt_dir_y[152:137]
	// tgt_dir_z[168:153], zero above
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic                 s_tlast,   // last_entry
	input  logic                 s_tuser,   // no_sources
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// result_value[31:0] target_index[51:32], zero above
	output logic [M_DATA_W-1:0]  m_tdata,
	output logic                 m_tuser,   // result_is_nan
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);
	cfg_t       cfg_q;
	dp_op_t     op;
	dp_status_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{metric: MET_SUM, fill: '0, nan_m2o: 1'b0, nan_o2m: 1'b0,
				ign_map: 1'b0, use_extra: 1'b0};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_METRIC:    cfg_q.metric    <= metric_sel_t'(cfg_data[1:0]);
				CFG_FILL:      cfg_q.fill      <= cfg_data;
				CFG_NAN_M2O:   cfg_q.nan_m2o   <= cfg_data[0];
				CFG_NAN_O2M:   cfg_q.nan_o2m   <= cfg_data[0];
				CFG_IGN_MAP:   cfg_q.ign_map   <= cfg_data[0];
				CFG_USE_EXTRA: cfg_q.use_extra <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	wga_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
		.stat(stat), .op(op)
	);

	wga_dp #(.MAX_SOURCES(MAX_SOURCES), .TARGET_COUNT(TARGET_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .cfg(cfg_q), .in_data(s_tdata),
		.in_last(s_tlast), .in_nosrc(s_tuser), .stat(stat), .m_tvalid(m_tvalid),
		.m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);
endmodule

@@ hw/rtl/wga_checker.sv @@
// Port-level checks for the weighted group aggregator, bound to its top level.
// Depends on wga_pkg for widths only.
module wga_checker import wga_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 s_tlast,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_DATA_W-1:0]  m_tdata,
	input logic                 m_tuser
);
	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	a_nan_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("NaN result carries a non-zero value");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken before the previous beat was processed");

	a_mid_run_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tlast && !s_tuser |=> !$rose(m_tvalid))
		else $error("result raised right after a mid-run entry");
endmodule

bind weighted_group_aggregator wga_checker u_wga_checker (.*);
